/* src/dcbc_pkg.sv */
// ----------------------------------------------------------------------------
// dcbc_pkg: shared types and constants of the chord blink controller
// Register indexes, reset values, counter widths and helper functions.
// ----------------------------------------------------------------------------
package dcbc_pkg;

  localparam int TIME_BITS = 16;
  localparam int CFG_W     = 16;
  localparam int FACTOR_W  = 4;
  localparam int IDX_W     = 3;
  localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  // The factor is kept as factor * ceil(2^23 / 10), so that one multiply by
  // the interval followed by a shift gives interval * factor / 10 exactly.
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 23;
  localparam int PROD_W      = CFG_W + RECIP_W;
  localparam int SCALED_W    = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(838861);

  localparam logic [IDX_W-1:0] REG_SLOW_INTERVAL  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FAST_INTERVAL  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_MIN_ACCEL      = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_DEBOUNCE_TICKS = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_COMBO_WINDOW   = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_ACCEL_FACTOR   = IDX_W'(5);

  localparam logic [CFG_W-1:0]    SLOW_RESET     = CFG_W'(2000);
  localparam logic [CFG_W-1:0]    FAST_RESET     = CFG_W'(250);
  localparam logic [CFG_W-1:0]    MIN_RESET      = CFG_W'(100);
  localparam logic [CFG_W-1:0]    DEBOUNCE_RESET = CFG_W'(50);
  localparam logic [CFG_W-1:0]    COMBO_RESET    = CFG_W'(150);
  localparam logic [FACTOR_W-1:0] FACTOR_RESET   = FACTOR_W'(5);

  typedef enum logic [1:0] {
    MODE_SLOW  = 2'd0,
    MODE_FAST  = 2'd1,
    MODE_ACCEL = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SLOW = 2'd1,
    KIND_FAST = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CFG_W-1:0]   slow_interval;
    logic [CFG_W-1:0]   fast_interval;
    logic [CFG_W-1:0]   min_accel_interval;
    logic [CFG_W-1:0]   debounce_ticks;
    logic [CFG_W-1:0]   combo_window;
    logic [RECIP_W-1:0] factor_recip;
  } cfg_t;

  function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic reached(input logic [TIME_BITS-1:0] cnt,
                                   input logic [CFG_W-1:0] limit);
    return CMP_W'(cnt) >= CMP_W'(limit);
  endfunction

endpackage

/* src/dcbc_debounce.sv */
// ----------------------------------------------------------------------------
// dcbc_debounce: settle-counter debouncer for one button
// Tracks the raw level, counts ticks without change and flags a stable press.
// ----------------------------------------------------------------------------
module dcbc_debounce import dcbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             first,
  input  logic             level,
  input  logic [CFG_W-1:0] ticks,
  output logic             stable_next,
  output logic             press
);

  logic                 raw;
  logic                 stable;
  logic [TIME_BITS-1:0] count;
  logic                 raw_next;
  logic [TIME_BITS-1:0] count_next;
  logic                 settle;

  always_comb begin
    raw_next    = level;
    count_next  = '0;
    stable_next = stable;
    press       = 1'b0;
    settle      = 1'b0;
    if (first) begin
      stable_next = level;
    end else begin
      if (level == raw) begin
        count_next = sat_inc(count);
      end
      settle = (raw_next != stable) && reached(count_next, ticks);
      if (settle) begin
        stable_next = raw_next;
        press       = raw_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw    <= 1'b0;
      stable <= 1'b0;
      count  <= '0;
    end else if (en) begin
      raw    <= raw_next;
      stable <= stable_next;
      count  <= count_next;
    end
  end

endmodule

/* src/dcbc_blink.sv */
// ----------------------------------------------------------------------------
// dcbc_blink: blink interval counter and LED toggle
// Counts ticks against the interval, toggles the LED and scales the interval
// in accelerating mode.
// ----------------------------------------------------------------------------
module dcbc_blink import dcbc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cfg_t  cfg,
  input  logic  enter,
  input  mode_t mode_cur,
  output logic  led_next
);

  logic [TIME_BITS-1:0] elapsed;
  logic [CFG_W-1:0]     interval;
  logic                 led_on;
  logic [CFG_W-1:0]     iv_cur;
  logic [TIME_BITS-1:0] el_inc;
  logic                 hit;
  logic [PROD_W-1:0]    prod;
  logic [SCALED_W-1:0]  scaled;
  logic [CFG_W-1:0]     scaled_sat;
  logic [CFG_W-1:0]     accel_iv;
  logic [CFG_W-1:0]     interval_next;

  always_comb begin
    iv_cur = interval;
    if (enter) begin
      iv_cur = (mode_cur == MODE_FAST) ? cfg.fast_interval : cfg.slow_interval;
    end
    el_inc     = sat_inc(elapsed);
    hit        = reached(el_inc, iv_cur);
    prod       = PROD_W'(iv_cur) * PROD_W'(cfg.factor_recip);
    scaled     = prod[PROD_W-1:RECIP_SHIFT];
    scaled_sat = (scaled > SCALED_W'({CFG_W{1'b1}})) ? {CFG_W{1'b1}} : scaled[CFG_W-1:0];
    accel_iv   = (scaled_sat <= cfg.min_accel_interval) ? cfg.slow_interval : scaled_sat;
    interval_next = (hit && mode_cur == MODE_ACCEL) ? accel_iv : iv_cur;
    led_next   = hit ? ~led_on : led_on;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed  <= '0;
      interval <= SLOW_RESET;
      led_on   <= 1'b0;
    end else if (en) begin
      elapsed  <= hit ? '0 : el_inc;
      interval <= interval_next;
      led_on   <= led_next;
    end
  end

endmodule

/* src/debounced_chord_blink_controller.sv */
// ----------------------------------------------------------------------------
// debounced_chord_blink_controller: two-button blink controller
// Debounces two buttons, selects slow, fast or accelerating blink mode and
// drives two complementary LEDs.
// ----------------------------------------------------------------------------
// Each word on the s_ channel is one millisecond tick carrying the raw levels
// of the slower and faster buttons. For every tick the block returns exactly
// one word on the m_ channel with both LED levels, the current mode and a
// flag that is high when a mode was entered on that tick.
// A tick is held in an input register, processed by one pass of counter and
// compare logic, and written to the output register together with the state
// update once that register is free; one tick is accepted per cycle while
// m_tready is high. The longest path is the interval scaling multiply. The
// cfg port writes one register per cycle with cfg_wen high. Writes are to be
// made while no tick is in flight, unenforced by the block, and take effect
// on the next tick. Reset clears the control state, loads register defaults
// and sets slow mode, primary LED off. The first tick after reset latches the
// button levels undebounced. While m_tready is low the output word holds,
// one more tick waits in the input register, and then s_tready drops.
// ----------------------------------------------------------------------------
module debounced_chord_blink_controller import dcbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [0] slower_level, [1] faster_level
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [0] led_primary, [1] led_secondary,
                                      // [3:2] blink_mode, [4] mode_changed
  input  logic             cfg_wen,
  input  logic [IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cfg_t                 cfg;
  logic                 in_valid;
  logic                 in_slow;
  logic                 in_fast;
  logic                 advance;
  logic                 started;
  kind_t                pend_kind;
  logic [TIME_BITS-1:0] pend_age;
  mode_t                mode_now;
  kind_t                kind_next;
  logic [TIME_BITS-1:0] age_next;
  mode_t                mode_next;
  mode_t                enter_mode;
  logic                 enter;
  logic                 slow_stable;
  logic                 fast_stable;
  logic                 slow_press;
  logic                 fast_press;
  logic                 led_next;
  logic                 out_valid;
  logic                 out_led;
  mode_t                out_mode;
  logic                 out_changed;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_interval      <= SLOW_RESET;
      cfg.fast_interval      <= FAST_RESET;
      cfg.min_accel_interval <= MIN_RESET;
      cfg.debounce_ticks     <= DEBOUNCE_RESET;
      cfg.combo_window       <= COMBO_RESET;
      cfg.factor_recip       <= RECIP_W'(FACTOR_RESET) * RECIP_MUL;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_SLOW_INTERVAL:  cfg.slow_interval      <= cfg_wdata;
        REG_FAST_INTERVAL:  cfg.fast_interval      <= cfg_wdata;
        REG_MIN_ACCEL:      cfg.min_accel_interval <= cfg_wdata;
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks     <= cfg_wdata;
        REG_COMBO_WINDOW:   cfg.combo_window       <= cfg_wdata;
        REG_ACCEL_FACTOR: begin
          cfg.factor_recip <= RECIP_W'(cfg_wdata[FACTOR_W-1:0]) * RECIP_MUL;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_slow <= s_tdata[0];
      in_fast <= s_tdata[1];
    end
  end

  dcbc_debounce u_slow_db (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .first       (!started),
    .level       (in_slow),
    .ticks       (cfg.debounce_ticks),
    .stable_next (slow_stable),
    .press       (slow_press)
  );

  dcbc_debounce u_fast_db (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .first       (!started),
    .level       (in_fast),
    .ticks       (cfg.debounce_ticks),
    .stable_next (fast_stable),
    .press       (fast_press)
  );

  always_comb begin
    kind_next  = pend_kind;
    age_next   = pend_age;
    enter      = 1'b0;
    enter_mode = MODE_SLOW;
    if (started) begin
      if (slow_stable && fast_stable) begin
        kind_next = KIND_NONE;
        age_next  = '0;
        if (mode_now != MODE_ACCEL) begin
          enter      = 1'b1;
          enter_mode = MODE_ACCEL;
        end
      end else begin
        if (slow_press) begin
          kind_next = KIND_SLOW;
          age_next  = '0;
        end else if (fast_press) begin
          kind_next = KIND_FAST;
          age_next  = '0;
        end else if (pend_kind != KIND_NONE) begin
          age_next = sat_inc(pend_age);
        end
        if (kind_next != KIND_NONE && reached(age_next, cfg.combo_window)) begin
          enter      = 1'b1;
          enter_mode = (kind_next == KIND_SLOW) ? MODE_SLOW : MODE_FAST;
          kind_next  = KIND_NONE;
          age_next   = '0;
        end
      end
    end
    mode_next = enter ? enter_mode : mode_now;
  end

  dcbc_blink u_blink (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .cfg      (cfg),
    .enter    (enter),
    .mode_cur (mode_next),
    .led_next (led_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      pend_kind <= KIND_NONE;
      pend_age  <= '0;
      mode_now  <= MODE_SLOW;
    end else if (advance) begin
      started   <= 1'b1;
      pend_kind <= kind_next;
      pend_age  <= age_next;
      mode_now  <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_led     <= led_next;
      out_mode    <= mode_next;
      out_changed <= enter;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_changed, out_mode, ~out_led, out_led};

  a_led_complement: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1] != m_tdata[0]))
    else $error("secondary LED is not the inverse of the primary LED");

  a_chord_clears_pending: assert property (@(posedge clk) disable iff (rst)
    (advance && started && slow_stable && fast_stable) |=> (pend_kind == KIND_NONE))
    else $error("an action is pending while both buttons are held");

  a_first_tick_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && !started) |=> !out_changed)
    else $error("the first tick reported a mode change");

  a_no_output_before_start: assert property (@(posedge clk) disable iff (rst)
    !started |-> !out_valid)
    else $error("a result was presented before the first tick");

endmodule

/* verif/tb_debounced_chord_blink_controller.sv */
// ----------------------------------------------------------------------------
// tb_debounced_chord_blink_controller: self-checking bench of the controller
// Feeds button ticks through the input stream under random idling on both
// sides and compares every output word, field by field, against an
// in-bench prediction of the debounce, chord, pending action and blink logic.
// Register settings vary from phase to phase, including all-zero and all-ones.
// ----------------------------------------------------------------------------
module tb_debounced_chord_blink_controller;
  import dcbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_CEIL = (1 << TIME_BITS) - 1;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(7);
  localparam int STYLE_RANDOM = 0;
  localparam int STYLE_MAX    = 1;
  localparam int STYLE_MIN    = 2;
  // Bit 0 is the slower button, bit 1 the faster button.
  localparam logic [1:0] OPENING [18] = '{
    2'b11, 2'b11, 2'b11, 2'b11, 2'b00, 2'b01, 2'b00, 2'b10, 2'b10,
    2'b00, 2'b01, 2'b11, 2'b10, 2'b00, 2'b00, 2'b01, 2'b01, 2'b00
  };

  typedef struct {
    bit slower;
    bit faster;
  } tick_t;

  typedef struct {
    bit    led_pri;
    bit    led_sec;
    mode_t mode;
    bit    changed;
  } blink_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;
  logic             cfg_wen = 1'b0;
  logic [IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  tick_t       tick_backlog [$];
  blink_word_t led_words_due [$];
  int unsigned queued_ticks = 0;
  int unsigned accepted_ticks = 0;
  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  bit          idling_on = 1'b1;

  // Predicted register file and controller state.
  logic [CFG_W-1:0]    slow_iv, fast_iv, min_iv, debounce_len, combo_len;
  logic [FACTOR_W-1:0] factor;
  bit          primed, slow_raw, fast_raw, slow_held, fast_held, led;
  int unsigned slow_cnt, fast_cnt, arm_age, elapsed, cur_iv;
  kind_t       armed;
  mode_t       mode;

  debounced_chord_blink_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned bump(input int unsigned v);
    return (v >= COUNT_CEIL) ? COUNT_CEIL : v + 1;
  endfunction

  function automatic bit settle_button(input bit level, inout bit raw, inout bit held,
                                       inout int unsigned cnt);
    if (level != raw) begin
      raw = level;
      cnt = 0;
    end else begin
      cnt = bump(cnt);
    end
    if (raw != held && cnt >= debounce_len) begin
      held = raw;
      return held;
    end
    return 1'b0;
  endfunction

  task automatic enter_mode(input mode_t m);
    mode = m;
    cur_iv = (m == MODE_FAST) ? fast_iv : slow_iv;
  endtask

  task automatic reset_prediction();
    slow_iv = SLOW_RESET;
    fast_iv = FAST_RESET;
    min_iv = MIN_RESET;
    debounce_len = DEBOUNCE_RESET;
    combo_len = COMBO_RESET;
    factor = FACTOR_RESET;
    primed = 1'b0;
    slow_raw = 1'b0;
    fast_raw = 1'b0;
    slow_held = 1'b0;
    fast_held = 1'b0;
    led = 1'b0;
    slow_cnt = 0;
    fast_cnt = 0;
    arm_age = 0;
    elapsed = 0;
    cur_iv = SLOW_RESET;
    armed = KIND_NONE;
    mode = MODE_SLOW;
  endtask

  task automatic predict_blink_word(input bit sl, input bit fs);
    bit          sl_edge, fs_edge, changed;
    int unsigned scaled;
    blink_word_t w;
    changed = 1'b0;
    if (!primed) begin
      slow_raw = sl;
      fast_raw = fs;
      slow_held = sl;
      fast_held = fs;
      slow_cnt = 0;
      fast_cnt = 0;
      primed = 1'b1;
    end else begin
      sl_edge = settle_button(sl, slow_raw, slow_held, slow_cnt);
      fs_edge = settle_button(fs, fast_raw, fast_held, fast_cnt);
      if (slow_held && fast_held) begin
        armed = KIND_NONE;
        arm_age = 0;
        if (mode != MODE_ACCEL) begin
          enter_mode(MODE_ACCEL);
          changed = 1'b1;
        end
      end else begin
        if (sl_edge) begin
          armed = KIND_SLOW;
          arm_age = 0;
        end else if (fs_edge) begin
          armed = KIND_FAST;
          arm_age = 0;
        end else if (armed != KIND_NONE) begin
          arm_age = bump(arm_age);
        end
        if (armed != KIND_NONE && arm_age >= combo_len) begin
          enter_mode((armed == KIND_SLOW) ? MODE_SLOW : MODE_FAST);
          armed = KIND_NONE;
          arm_age = 0;
          changed = 1'b1;
        end
      end
    end
    elapsed = bump(elapsed);
    if (elapsed >= cur_iv) begin
      elapsed = 0;
      led = !led;
      if (mode == MODE_ACCEL) begin
        scaled = (cur_iv * factor) / 10;
        if (scaled > 65535) scaled = 65535;
        if (scaled <= min_iv) scaled = slow_iv;
        cur_iv = scaled;
      end
    end
    w.led_pri = led;
    w.led_sec = !led;
    w.mode = mode;
    w.changed = changed;
    led_words_due.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= 40) begin
      $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_SLOW_INTERVAL:  slow_iv = value;
      REG_FAST_INTERVAL:  fast_iv = value;
      REG_MIN_ACCEL:      min_iv = value;
      REG_DEBOUNCE_TICKS: debounce_len = value;
      REG_COMBO_WINDOW:   combo_len = value;
      REG_ACCEL_FACTOR:   factor = value[FACTOR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input int style);
    logic [CFG_W-1:0] value;
    for (int r = 0; r <= 5; r++) begin
      case (style)
        STYLE_MAX: value = '1;
        STYLE_MIN: value = (r == REG_ACCEL_FACTOR) ? CFG_W'(16'hFFF0) : '0;
        default: begin
          if (r == REG_ACCEL_FACTOR) begin
            value = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom)
                                                : CFG_W'($urandom_range(1, 9));
          end else if ($urandom_range(0, 7) == 0) begin
            value = ($urandom_range(0, 1) == 1) ? '1 : CFG_W'($urandom);
          end else begin
            value = CFG_W'($urandom_range(0, (r == REG_MIN_ACCEL) ? 20 : 10));
          end
        end
      endcase
      if (style != STYLE_RANDOM || $urandom_range(0, 3) != 0) begin
        write_reg(IDX_W'(r), value);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
    end
    cfg_wen <= 1'b0;
  endtask

  task automatic push_tick(input bit sl, input bit fs);
    tick_t t;
    t.slower = sl;
    t.faster = fs;
    tick_backlog.push_back(t);
    queued_ticks++;
  endtask

  // Holds of random level pairs, sized around the debounce and window lengths,
  // mixed with single-tick bounces.
  task automatic queue_ticks(input int count);
    int pushed, run, pattern, reach;
    pushed = 0;
    reach = (debounce_len + combo_len < 14) ? debounce_len + combo_len + 3 : 16;
    while (pushed < count) begin
      pattern = $urandom_range(0, 3);
      run = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, reach);
      for (int k = 0; k < run && pushed < count; k++) begin
        push_tick(pattern[0], pattern[1]);
        pushed++;
      end
    end
  endtask

  task automatic drain();
    while (!(accepted_ticks == queued_ticks && led_words_due.size() == 0)) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    tick_t t;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_blink_word(s_tdata[0], s_tdata[1]);
        accepted_ticks++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (tick_backlog.size() > 0) begin
          t = tick_backlog.pop_front();
          s_tdata <= {6'b0, t.faster, t.slower};
          s_tvalid <= 1'b1;
          if (idling_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 7);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    blink_word_t w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (led_words_due.size() == 0) begin
          report_mismatch("unexpected word", m_tdata, 0);
        end else begin
          w = led_words_due.pop_front();
          if (m_tdata[0] != w.led_pri) report_mismatch("led_primary", m_tdata[0], w.led_pri);
          if (m_tdata[1] != w.led_sec) report_mismatch("led_secondary", m_tdata[1], w.led_sec);
          if (m_tdata[3:2] != w.mode) report_mismatch("blink_mode", m_tdata[3:2], w.mode);
          if (m_tdata[4] != w.changed) report_mismatch("mode_changed", m_tdata[4], w.changed);
          if (m_tdata[7:5] != 3'b000) report_mismatch("padding", m_tdata[7:5], 0);
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (idling_on && $urandom_range(0, 9) == 0) take_gap = $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wen || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_debounced_chord_blink_controller: errors");
        $finish;
      end
    end
  end

  initial begin
    reset_prediction();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Short intervals and zero debounce and window, so that the chord, the
    // acceleration restart and same-tick actions show up at once.
    write_reg(REG_SLOW_INTERVAL, CFG_W'(3));
    write_reg(REG_FAST_INTERVAL, CFG_W'(1));
    write_reg(REG_MIN_ACCEL, CFG_W'(1));
    write_reg(REG_DEBOUNCE_TICKS, CFG_W'(0));
    write_reg(REG_COMBO_WINDOW, CFG_W'(0));
    write_reg(REG_ACCEL_FACTOR, CFG_W'(5));
    cfg_wen <= 1'b0;
    foreach (OPENING[i]) push_tick(OPENING[i][0], OPENING[i][1]);
    drain();

    configure(STYLE_MAX);
    queue_ticks(40);
    drain();
    configure(STYLE_MIN);
    queue_ticks(40);
    drain();
    for (int p = 0; p < 8; p++) begin
      configure(STYLE_RANDOM);
      if (p == 7) idling_on = 1'b0;
      queue_ticks(45);
      drain();
    end

    repeat (6) @(posedge clk);
    if (led_words_due.size() != 0) report_mismatch("words missing", led_words_due.size(), 0);
    if (error_count == 0) begin
      $display("tb_debounced_chord_blink_controller: clean");
    end else begin
      $display("tb_debounced_chord_blink_controller: errors");
    end
    $finish;
  end

endmodule

/* debounced_chord_blink_controller.f */
src/dcbc_pkg.sv
src/dcbc_debounce.sv
src/dcbc_blink.sv
src/debounced_chord_blink_controller.sv
verif/tb_debounced_chord_blink_controller.sv
